### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define LZ4D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// a stalled transfer keeps valid and payload
`define LZ4D_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  `LZ4D_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> (vld && $stable(sig)), msg)

`endif

### src/lz4d_pkg.sv
// types, codes and helper functions of the lz4 block decompressor
package lz4d_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 65536;

  // item kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_CONT    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [3:0]  NIBBLE_EXT = 4'hF;
  localparam logic [7:0]  BYTE_EXT   = 8'hFF;
  localparam logic [32:0] MIN_MATCH  = 33'd4;
  localparam logic [32:0] LEN_SAT    = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LIT_EXT,
    PH_LITERALS,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATCH_EXT,
    PH_COPY,
    PH_END
  } lz4d_phase_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DONE,
    ST_TRUNC,
    ST_ZERO_OFF,
    ST_UNDERFLOW,
    ST_CAPACITY,
    ST_PROTOCOL
  } lz4d_status_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_byte;
    logic       last_byte;
  } lz4d_in_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        copy_pending;
    logic [2:0]  status;
    logic [31:0] total_len;
  } lz4d_out_t;

  // length add that stops at 2^32
  function automatic logic [32:0] sat_add(logic [32:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, LEN_SAT}) ? LEN_SAT : s[32:0];
  endfunction

  function automatic logic over_cap(logic [31:0] cnt, logic [32:0] len, logic [31:0] cap);
    logic [33:0] s;
    s = {2'b00, cnt} + {1'b0, len};
    return s > {2'b00, cap};
  endfunction

endpackage

### src/lz4d_hist.sv
// history window memory, one write and one registered read port
module lz4d_hist #(
  parameter int unsigned WINDOW_DEPTH = lz4d_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] waddr_i,
  input  logic [7:0]                      wdata_i,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] raddr_i,
  output logic [7:0]                      rdata_o
);
  import lz4d_pkg::*;

  logic [7:0] mem_q [WINDOW_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-through when the byte written now is the one read
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/lz4d_engine.sv
// sequence parser, match copier and block state
module lz4d_engine #(
  parameter int unsigned WINDOW_DEPTH = lz4d_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  lz4d_pkg::lz4d_in_t              item_i,
  input  logic [31:0]                     cap_i,
  input  logic [7:0]                      hist_rdata_i,
  output lz4d_pkg::lz4d_out_t             result_o,
  output logic                            hist_we_o,
  output logic [$clog2(WINDOW_DEPTH)-1:0] hist_waddr_o,
  output logic [7:0]                      hist_wdata_o,
  output logic [$clog2(WINDOW_DEPTH)-1:0] hist_raddr_o
);
  import lz4d_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  lz4d_phase_e  phase_q, phase_d;
  lz4d_status_e fin_q, fin_d;
  logic [32:0]  lit_q, lit_d;
  logic [32:0]  mat_q, mat_d;
  logic [15:0]  off_q, off_d;
  logic [31:0]  cnt_q, cnt_d;
  logic [3:0]   nib_q, nib_d;
  logic [AW-1:0] wptr_q, wptr_d;

  logic        emit;
  logic [7:0]  emit_byte;
  logic [32:0] len_a, len_b;
  logic [15:0] off_new;
  logic [7:0]  b;
  logic        last;
  logic [AW:0] diff, diff_wrap;

  assign b    = item_i.in_byte;
  assign last = item_i.last_byte;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    lit_d     = lit_q;
    mat_d     = mat_q;
    off_d     = off_q;
    cnt_d     = cnt_q;
    nib_d     = nib_q;
    wptr_d    = wptr_q;
    emit      = 1'b0;
    emit_byte = 8'h00;
    len_a     = sat_add(lit_q, {25'd0, b});
    len_b     = sat_add(mat_q, {25'd0, b});
    off_new   = {b, off_q[7:0]};
    if (step_i) begin
      if (item_i.kind == KIND_RESTART) begin
        phase_d = PH_TOKEN;
        fin_d   = ST_RUN;
        lit_d   = '0;
        mat_d   = '0;
        off_d   = '0;
        cnt_d   = '0;
        nib_d   = '0;
        wptr_d  = '0;
      end else if (phase_q != PH_END) begin
        if (item_i.kind == KIND_BYTE) begin
          case (phase_q)
            PH_TOKEN: begin
              lit_d = {29'd0, b[7:4]};
              nib_d = b[3:0];
              if (b[7:4] == NIBBLE_EXT) begin
                if (last) begin
                  phase_d = PH_END; fin_d = ST_TRUNC;
                end else begin
                  phase_d = PH_LIT_EXT;
                end
              end else if (b[7:4] != 4'd0) begin
                if (last) begin
                  phase_d = PH_END; fin_d = ST_TRUNC;
                end else if (over_cap(cnt_q, {29'd0, b[7:4]}, cap_i)) begin
                  phase_d = PH_END; fin_d = ST_CAPACITY;
                end else begin
                  phase_d = PH_LITERALS;
                end
              end else if (last) begin
                phase_d = PH_END; fin_d = ST_DONE;
              end else begin
                phase_d = PH_OFF_LO;
              end
            end
            PH_LIT_EXT: begin
              lit_d = len_a;
              if (b == BYTE_EXT) begin
                if (last) begin
                  phase_d = PH_END; fin_d = ST_TRUNC;
                end
              end else if (last) begin
                phase_d = PH_END; fin_d = ST_TRUNC;
              end else if (over_cap(cnt_q, len_a, cap_i)) begin
                phase_d = PH_END; fin_d = ST_CAPACITY;
              end else begin
                phase_d = PH_LITERALS;
              end
            end
            PH_LITERALS: begin
              if (last && (lit_q > 33'd1)) begin
                phase_d = PH_END; fin_d = ST_TRUNC;
              end else begin
                emit      = 1'b1;
                emit_byte = b;
                lit_d     = lit_q - 33'd1;
                if (lit_q == 33'd1) begin
                  if (last) begin
                    phase_d = PH_END; fin_d = ST_DONE;
                  end else begin
                    phase_d = PH_OFF_LO;
                  end
                end
              end
            end
            PH_OFF_LO: begin
              off_d = {8'h00, b};
              if (last) begin
                phase_d = PH_END; fin_d = ST_TRUNC;
              end else begin
                phase_d = PH_OFF_HI;
              end
            end
            PH_OFF_HI: begin
              off_d = off_new;
              if (off_new == 16'd0) begin
                phase_d = PH_END; fin_d = ST_ZERO_OFF;
              end else if (nib_q == NIBBLE_EXT) begin
                mat_d = 33'd15;
                if (last) begin
                  phase_d = PH_END; fin_d = ST_TRUNC;
                end else begin
                  phase_d = PH_MATCH_EXT;
                end
              end else begin
                mat_d = {29'd0, nib_q} + MIN_MATCH;
                if ({16'd0, off_new} > cnt_q) begin
                  phase_d = PH_END; fin_d = ST_UNDERFLOW;
                end else if (over_cap(cnt_q, {29'd0, nib_q} + MIN_MATCH, cap_i)) begin
                  phase_d = PH_END; fin_d = ST_CAPACITY;
                end else if (last) begin
                  phase_d = PH_END; fin_d = ST_TRUNC;
                end else begin
                  phase_d = PH_COPY;
                end
              end
            end
            PH_MATCH_EXT: begin
              if (b == BYTE_EXT) begin
                mat_d = len_b;
                if (last) begin
                  phase_d = PH_END; fin_d = ST_TRUNC;
                end
              end else begin
                mat_d = sat_add(len_b, MIN_MATCH);
                if ({16'd0, off_q} > cnt_q) begin
                  phase_d = PH_END; fin_d = ST_UNDERFLOW;
                end else if (over_cap(cnt_q, sat_add(len_b, MIN_MATCH), cap_i)) begin
                  phase_d = PH_END; fin_d = ST_CAPACITY;
                end else if (last) begin
                  phase_d = PH_END; fin_d = ST_TRUNC;
                end else begin
                  phase_d = PH_COPY;
                end
              end
            end
            PH_COPY: begin
              phase_d = PH_END; fin_d = ST_PROTOCOL;
            end
            default: begin
            end
          endcase
        end else if ((item_i.kind == KIND_CONT) && (phase_q == PH_COPY)) begin
          emit      = 1'b1;
          emit_byte = hist_rdata_i;
          mat_d     = mat_q - 33'd1;
          if (mat_q == 33'd1) begin
            phase_d = PH_TOKEN;
          end
        end else begin
          phase_d = PH_END; fin_d = ST_PROTOCOL;
        end
      end
      if (emit) begin
        cnt_d  = cnt_q + 32'd1;
        wptr_d = (wptr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
    end
  end

  // source of the next copy byte, taken from the state after this step
  always_comb begin
    diff      = {1'b0, wptr_d} - (AW + 1)'(off_d);
    diff_wrap = diff + (AW + 1)'(WINDOW_DEPTH);
    hist_raddr_o = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
  end

  assign hist_we_o    = emit;
  assign hist_waddr_o = wptr_q;
  assign hist_wdata_o = emit_byte;

  always_comb begin
    result_o.out_valid    = emit;
    result_o.out_byte     = emit_byte;
    result_o.copy_pending = (phase_d == PH_COPY);
    result_o.status       = (phase_d == PH_END) ? fin_d : ST_RUN;
    result_o.total_len    = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN;
      fin_q   <= ST_RUN;
      lit_q   <= '0;
      mat_q   <= '0;
      off_q   <= '0;
      cnt_q   <= '0;
      nib_q   <= '0;
      wptr_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      lit_q   <= lit_d;
      mat_q   <= mat_d;
      off_q   <= off_d;
      cnt_q   <= cnt_d;
      nib_q   <= nib_d;
      wptr_q  <= wptr_d;
    end
  end

endmodule

### src/lz4_block_decompressor_core.sv
// lz4 block decompressor: one compressed byte or one match byte per cycle, one
// result per item. An accepted item is held in the input register while
// the engine decodes it, its result is written to the output register when
// the item moves on to the output stage, and a new item is taken every cycle
// as long as the output side keeps taking results. The rate is set by the
// history memory: one write and one registered read per cycle, with the read
// address formed from the state the current item leaves, so a continue item
// that directly follows finds its byte ready (a write-through covers offset
// one). History needs no clearing pass after reset.
module lz4_block_decompressor_core #(
  parameter int unsigned WINDOW_DEPTH = lz4d_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lz4d_pkg::lz4d_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lz4d_pkg::lz4d_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);
  import lz4d_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  // input register
  logic     s1_valid_q, s1_valid_d;
  lz4d_in_t s1_item_q;
  // output register
  logic      res_valid_q, res_valid_d;
  lz4d_out_t res_q;
  // capacity register
  logic [31:0] cap_q;

  logic          step;
  lz4d_out_t     eng_result;
  logic          hist_we;
  logic [AW-1:0] hist_waddr, hist_raddr;
  logic [7:0]    hist_wdata, hist_rdata;

  // item in the input register moves on when the output register is free or being read
  assign step       = s1_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    res_valid_d = res_valid_q;
    if (step) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      cap_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (step) begin
      res_q <= eng_result;
    end
  end

  lz4d_engine #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (s1_item_q),
    .cap_i       (cap_q),
    .hist_rdata_i(hist_rdata),
    .result_o    (eng_result),
    .hist_we_o   (hist_we),
    .hist_waddr_o(hist_waddr),
    .hist_wdata_o(hist_wdata),
    .hist_raddr_o(hist_raddr)
  );

  lz4d_hist #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  // result transfer
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

### src/lz4d_checker.sv
// port checker for the lz4 block decompressor and its bind
`include "assert_macros.svh"

module lz4d_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input lz4d_pkg::lz4d_out_t out_data_i
);
  import lz4d_pkg::*;

  `LZ4D_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_data_i, "stalled result changed")

  `LZ4D_ASSERT(a_byte_zero, clk_i, rst_ni, out_valid_i |-> (out_data_i.out_valid || (out_data_i.out_byte == 8'h00)), "out_byte set without out_valid")

  // no byte or copy after block end, but the closing literal of a good block comes out together with done
  `LZ4D_ASSERT(a_end_quiet, clk_i, rst_ni, (out_valid_i && (out_data_i.status != ST_RUN)) |-> (!out_data_i.copy_pending && (!out_data_i.out_valid || (out_data_i.status == ST_DONE))), "byte or copy after block end")

  `LZ4D_ASSERT(a_len_counts, clk_i, rst_ni, (out_valid_i && out_data_i.out_valid) |-> (out_data_i.total_len != 32'd0), "byte sent with zero length")

endmodule

bind lz4_block_decompressor_core lz4d_checker u_lz4d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);

### test/tb_lz4_block_decompressor_core.sv
// self-checking testbench for the lz4 block decompressor core
`timescale 1ns / 1ps

module tb_lz4_block_decompressor_core;
  import lz4d_pkg::*;

  // code 3 of the kind field has no meaning, the decoder must reject it
  localparam logic [1:0] KIND_BAD = 2'd3;
  // cycles in a row without any transfer before the run is declared hung
  localparam int unsigned HANG_LIMIT = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  lz4d_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  lz4d_out_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  lz4_block_decompressor_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // decoder mirror: parse state, counters and the history window
  lz4d_phase_e  dec_phase;
  lz4d_status_e end_code;
  logic [32:0]  lit_left;
  logic [32:0]  copy_left;
  logic [15:0]  copy_offs;
  logic [3:0]   match_code;
  logic [31:0]  produced;
  logic [31:0]  cap_limit;
  logic [7:0]   window_mem [0:65535];
  lz4d_out_t    step_res;

  lz4d_out_t    pending_results [$];
  lz4d_in_t     frame_q [$];
  int unsigned  mismatches = 0;
  int unsigned  live_items = 0;
  int unsigned  quiet_cycles = 0;
  // percent chance of an idle burst, per item sent and per result-side check
  int unsigned  idle_pct = 10;

  // ---------------------------------------------------------------------
  // decoder mirror
  // ---------------------------------------------------------------------

  // restart: everything but history and capacity goes back to its start value
  function automatic void clear_decoder();
    dec_phase  = PH_TOKEN;
    end_code   = ST_RUN;
    lit_left   = '0;
    copy_left  = '0;
    copy_offs  = '0;
    match_code = '0;
    produced   = '0;
  endfunction

  // length growth stops at 2^32
  function automatic logic [32:0] len_sum(logic [32:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 34'h1_0000_0000) ? 33'h1_0000_0000 : s[32:0];
  endfunction

  function automatic bit exceeds_room(logic [32:0] len);
    logic [33:0] need;
    need = {2'b00, produced} + {1'b0, len};
    return need > {2'b00, cap_limit};
  endfunction

  function automatic void stop_block(lz4d_status_e code);
    end_code  = code;
    dec_phase = PH_END;
  endfunction

  // every produced byte lands in the window at its index mod the depth
  function automatic void put_out(logic [7:0] b);
    window_mem[produced[15:0]] = b;
    produced = produced + 32'd1;
    step_res.out_valid = 1'b1;
    step_res.out_byte  = b;
  endfunction

  // truncation on a flagged byte wins over the capacity check here
  function automatic void lits_known(logic last);
    if (last) stop_block(ST_TRUNC);
    else if (exceeds_room(lit_left)) stop_block(ST_CAPACITY);
    else dec_phase = PH_LITERALS;
  endfunction

  // match checks: underflow, then capacity, then truncation
  function automatic void match_known(logic last);
    if ({16'd0, copy_offs} > produced) stop_block(ST_UNDERFLOW);
    else if (exceeds_room(copy_left)) stop_block(ST_CAPACITY);
    else if (last) stop_block(ST_TRUNC);
    else dec_phase = PH_COPY;
  endfunction

  function automatic void take_byte(logic [7:0] b, logic last);
    case (dec_phase)
      PH_TOKEN: begin
        lit_left   = {29'd0, b[7:4]};
        match_code = b[3:0];
        if (b[7:4] == NIBBLE_EXT) begin
          if (last) stop_block(ST_TRUNC);
          else dec_phase = PH_LIT_EXT;
        end else if (b[7:4] != 4'd0) begin
          lits_known(last);
        end else if (last) begin
          stop_block(ST_DONE);
        end else begin
          dec_phase = PH_OFF_LO;
        end
      end
      PH_LIT_EXT: begin
        lit_left = len_sum(lit_left, {25'd0, b});
        if (b == BYTE_EXT) begin
          if (last) stop_block(ST_TRUNC);
        end else begin
          lits_known(last);
        end
      end
      PH_LITERALS: begin
        // a flagged literal with more still owed is dropped
        if (last && lit_left > 33'd1) begin
          stop_block(ST_TRUNC);
        end else begin
          put_out(b);
          lit_left = lit_left - 33'd1;
          if (lit_left == 33'd0) begin
            if (last) stop_block(ST_DONE);
            else dec_phase = PH_OFF_LO;
          end
        end
      end
      PH_OFF_LO: begin
        copy_offs = {8'd0, b};
        if (last) stop_block(ST_TRUNC);
        else dec_phase = PH_OFF_HI;
      end
      PH_OFF_HI: begin
        copy_offs[15:8] = b;
        if (copy_offs == 16'd0) begin
          stop_block(ST_ZERO_OFF);
        end else if (match_code == NIBBLE_EXT) begin
          copy_left = 33'd15;
          if (last) stop_block(ST_TRUNC);
          else dec_phase = PH_MATCH_EXT;
        end else begin
          copy_left = {29'd0, match_code} + 33'd4;
          match_known(last);
        end
      end
      PH_MATCH_EXT: begin
        copy_left = len_sum(copy_left, {25'd0, b});
        if (b == BYTE_EXT) begin
          if (last) stop_block(ST_TRUNC);
        end else begin
          copy_left = len_sum(copy_left, 33'd4);
          match_known(last);
        end
      end
      PH_COPY: stop_block(ST_PROTOCOL);
      default: ;
    endcase
  endfunction

  // one item in, the one result it causes out
  function automatic lz4d_out_t decode_item(lz4d_in_t it);
    logic [15:0] src;
    step_res = '0;
    if (it.kind == KIND_RESTART) begin
      clear_decoder();
    end else if (dec_phase != PH_END) begin
      if (it.kind == KIND_BYTE) begin
        take_byte(it.in_byte, it.last_byte);
      end else if (it.kind == KIND_CONT && dec_phase == PH_COPY) begin
        src = produced[15:0] - copy_offs;
        put_out(window_mem[src]);
        copy_left = copy_left - 33'd1;
        if (copy_left == 33'd0) dec_phase = PH_TOKEN;
      end else begin
        stop_block(ST_PROTOCOL);
      end
    end
    step_res.copy_pending = (dec_phase == PH_COPY);
    step_res.status       = (dec_phase == PH_END) ? end_code : ST_RUN;
    step_res.total_len    = produced;
    return step_res;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(lz4d_out_t got);
    lz4d_out_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result expected none actual %h", $time, got);
    end else begin
      want = pending_results.pop_front();
      compare_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
      compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      compare_field("copy_pending", 32'(want.copy_pending), 32'(got.copy_pending));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("total_len", want.total_len, got.total_len);
    end
  endtask

  // results are checked before the item of the same edge is predicted, so
  // an item can never be matched with a result it could not have caused
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if (in_valid_i && in_ready_o) begin
        // items after the end of a block are ignored and not counted
        if (in_data_i.kind == KIND_RESTART || dec_phase != PH_END) live_items++;
        pending_results.push_back(decode_item(in_data_i));
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // hang detection
  initial begin
    while (quiet_cycles < HANG_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  // result side: ready with random stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // drives one item and returns at the edge of its transfer, valid still high
  task automatic send_item(logic [1:0] kind, logic [7:0] b, logic last);
    lz4d_in_t it;
    it.kind      = kind;
    it.in_byte   = b;
    it.last_byte = last;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    send_item(KIND_BYTE, b, last);
  endtask

  // restart, continue and bad kinds carry random byte and flag bits
  task automatic send_ctrl(logic [1:0] kind);
    send_item(kind, 8'($urandom), 1'($urandom));
  endtask

  // hold off until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_capacity(logic [31:0] v);
    drain();
    // let the two-stage pipe settle before touching the register
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_limit = v;
  endtask

  task automatic push_item(logic [1:0] kind, logic [7:0] b, logic last);
    lz4d_in_t it;
    it.kind      = kind;
    it.in_byte   = b;
    it.last_byte = last;
    frame_q.push_back(it);
  endtask

  function automatic logic [3:0] len_nibble(int unsigned n);
    return (n >= 15) ? NIBBLE_EXT : n[3:0];
  endfunction

  // extension bytes: runs of 255 then the remainder
  task automatic push_ext(int unsigned rest);
    int unsigned r;
    r = rest;
    while (r >= 255) begin
      push_item(KIND_BYTE, BYTE_EXT, 1'b0);
      r = r - 255;
    end
    push_item(KIND_BYTE, r[7:0], 1'b0);
  endtask

  // one full sequence: token, literals, offset, match length and the copy
  task automatic push_sequence(int unsigned lit, int unsigned mlen, int unsigned offs);
    push_item(KIND_BYTE, {len_nibble(lit), len_nibble(mlen - 4)}, 1'b0);
    if (lit >= 15) push_ext(lit - 15);
    repeat (lit) push_item(KIND_BYTE, 8'($urandom), 1'b0);
    push_item(KIND_BYTE, offs[7:0], 1'b0);
    push_item(KIND_BYTE, offs[15:8], 1'b0);
    if (mlen >= 19) push_ext(mlen - 19);
    repeat (mlen) push_item(KIND_CONT, 8'($urandom), 1'($urandom));
  endtask

  // literal-only closing sequence, flag on its last byte
  task automatic push_final(int unsigned lit);
    int unsigned k;
    if (lit == 0) begin
      push_item(KIND_BYTE, {4'd0, 4'($urandom)}, 1'b1);
    end else begin
      push_item(KIND_BYTE, {len_nibble(lit), 4'($urandom)}, 1'b0);
      if (lit >= 15) push_ext(lit - 15);
      for (k = 0; k < lit; k++) push_item(KIND_BYTE, 8'($urandom), k == lit - 1);
    end
  endtask

  // mostly short lengths, now and then long enough for 255 extension runs
  function automatic int unsigned pick_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 300);
    return $urandom_range(0, 18);
  endfunction

  // a well-formed block with random content, optionally broken by bad offsets and in one place
  task automatic build_block(int unsigned n_seq, bit spoil);
    int unsigned made, lit, mlen, offs, s, idx;
    lz4d_in_t junk;
    frame_q.delete();
    push_item(KIND_RESTART, 8'($urandom), 1'($urandom));
    made = 0;
    for (s = 0; s < n_seq; s++) begin
      lit = pick_len();
      if (made == 0 && lit == 0) lit = 1;
      mlen = 4 + pick_len();
      made = made + lit;
      // short offsets give overlapping copies
      if ($urandom_range(0, 3) == 0) offs = $urandom_range(1, (made > 65535) ? 65535 : made);
      else offs = $urandom_range(1, (made > 8) ? 8 : made);
      if (spoil && $urandom_range(0, 9) == 0) begin
        // zero offset or one reaching before the start of the output
        offs = $urandom_range(0, 1) ? 0 : made + $urandom_range(1, 50);
        if (offs > 65535) offs = 65535;
      end
      push_sequence(lit, mlen, offs);
      made = made + mlen;
    end
    push_final(pick_len());
    if (spoil) begin
      idx = $urandom_range(1, frame_q.size() - 1);
      junk.kind      = ($urandom_range(0, 1) != 0) ? KIND_CONT : KIND_BYTE;
      junk.in_byte   = 8'($urandom);
      junk.last_byte = 1'($urandom);
      case ($urandom_range(0, 3))
        0: frame_q[idx].last_byte = 1'b1;
        1: begin
          junk.kind = 2'($urandom_range(0, 3));
          frame_q[idx] = junk;
        end
        2: frame_q.insert(idx, junk);
        default: begin
          // cut off mid-block, the next restart must recover
          while (frame_q.size() > idx) frame_q.delete(frame_q.size() - 1);
        end
      endcase
    end
    // a few stray items after the end sometimes
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) push_item(2'($urandom_range(0, 3)), 8'($urandom),
                                              1'($urandom));
    end
  endtask

  task automatic send_frame();
    int unsigned k;
    for (k = 0; k < frame_q.size(); k++) begin
      send_item(frame_q[k].kind, frame_q[k].in_byte, frame_q[k].last_byte);
    end
  endtask

  task automatic pick_idle();
    case ($urandom_range(0, 3))
      0: idle_pct = 0;
      1: idle_pct = 5;
      2: idle_pct = 20;
      default: idle_pct = 50;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // capacity still at its reset value of zero
  task automatic test_reset_capacity();
    send_byte(8'h00, 1'b1);       // empty block, done at once
    send_byte(8'h12, 1'b0);       // ignored after the end
    send_ctrl(KIND_CONT);         // ignored after the end
    send_ctrl(KIND_RESTART);
    send_byte(8'h20, 1'b0);       // two literals do not fit in zero bytes
  endtask

  // one literal replicated by an offset-one match
  task automatic test_overlap_copy();
    send_ctrl(KIND_RESTART);
    send_byte(8'h10, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (4) send_ctrl(KIND_CONT);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_error_codes();
    // zero offset
    send_ctrl(KIND_RESTART);
    send_byte(8'h10, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // offset reaching before the output start
    send_ctrl(KIND_RESTART);
    send_byte(8'h10, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    // continue with no copy pending, then the unused kind
    send_ctrl(KIND_RESTART);
    send_ctrl(KIND_CONT);
    send_ctrl(KIND_RESTART);
    send_ctrl(KIND_BAD);
    // compressed byte while a copy is pending
    send_ctrl(KIND_RESTART);
    send_byte(8'h10, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
    // flagged token that still owes literals, flagged 255 extension
    send_ctrl(KIND_RESTART);
    send_byte(8'h30, 1'b1);
    send_ctrl(KIND_RESTART);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b1);
    // flagged literal with one more owed is not emitted
    send_ctrl(KIND_RESTART);
    send_byte(8'h20, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_capacity_edge();
    set_capacity(32'd2);          // exact fit
    send_ctrl(KIND_RESTART);
    send_byte(8'h20, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b1);
    set_capacity(32'd1);          // one short
    send_ctrl(KIND_RESTART);
    send_byte(8'h20, 1'b0);
    set_capacity(32'd5);          // match of five after one literal overflows
    send_ctrl(KIND_RESTART);
    send_byte(8'h11, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // extended lengths on both sides, then copies from far back in the output
  task automatic test_long_copy();
    set_capacity(32'hFFFF_FFFF);
    idle_pct = 5;
    frame_q.delete();
    push_item(KIND_RESTART, 8'($urandom), 1'($urandom));
    push_sequence(120, 60, 120);
    push_sequence(0, 20, 150);
    push_sequence(0, 5, 200);
    push_final(3);
    send_frame();
  endtask

  task automatic test_random_blocks();
    int unsigned start, blk;
    start = live_items;
    blk = 0;
    while (live_items - start < 450) begin
      if (blk % 5 == 0) pick_idle();
      build_block($urandom_range(1, 4), $urandom_range(0, 3) == 0);
      send_frame();
      if ($urandom_range(0, 7) == 0) drain();
      blk++;
    end
  endtask

  task automatic test_capacity_sweep();
    int unsigned step;
    for (step = 0; step < 6; step++) begin
      case (step)
        0: set_capacity(32'd0);
        1: set_capacity($urandom_range(1, 60));
        2: set_capacity($urandom_range(60, 400));
        3: set_capacity($urandom);
        4: set_capacity(32'd1);
        default: set_capacity(32'hFFFF_FFFF);
      endcase
      pick_idle();
      repeat (2) begin
        build_block(1, $urandom_range(0, 4) == 0);
        send_frame();
      end
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_quiet_tail();
    int unsigned start;
    idle_pct = 0;
    start = live_items;
    while (live_items - start < 200) begin
      build_block($urandom_range(1, 4), $urandom_range(0, 3) == 0);
      send_frame();
    end
  endtask

  initial begin
    clear_decoder();
    cap_limit = 32'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_capacity();
    set_capacity(32'hFFFF_FFFF);
    test_overlap_copy();
    test_error_codes();
    test_capacity_edge();
    test_long_copy();
    test_random_blocks();
    test_capacity_sweep();
    test_quiet_tail();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/lz4d_pkg.sv
src/lz4d_hist.sv
src/lz4d_engine.sv
src/lz4_block_decompressor_core.sv
src/lz4d_checker.sv
test/tb_lz4_block_decompressor_core.sv
